[src/indexed_array_list_engine_core_macros.svh]
// assertion macros for the indexed array list engine checker
`ifndef INDEXED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define INDEXED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH

// checked only while out of reset
`define IAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IAL_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ial_pkg.sv]
// shared types and constants for the indexed array list engine
`timescale 1ns / 1ps
package ial_pkg;

  localparam int CMD_W          = 3;
  localparam int POS_W          = 7;
  localparam int VAL_W          = 32;
  localparam int CNT_OUT_W      = 7;
  localparam int STAT_W         = 2;
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int GROUP          = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND       = 3'd0,
    CMD_PREPEND      = 3'd1,
    CMD_INSERT       = 3'd2,
    CMD_REMOVE_END   = 3'd3,
    CMD_REMOVE_START = 3'd4,
    CMD_REMOVE_AT    = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2
  } cell_op_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_GATHER = 1'b1
  } state_t;

endpackage

[src/ial_cell.sv]
// one list entry: holds, loads a new word, or shifts from a neighbor
`timescale 1ns / 1ps
module ial_cell #(
  parameter int DW    = ial_pkg::DATA_WIDTH_DEF,
  parameter int CMP_W = ial_pkg::POS_W,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  ial_pkg::cell_op_t op_i,
  input  logic [CMP_W-1:0]  at_i,
  input  logic [CMP_W-1:0]  hi_i,
  input  logic [DW-1:0]     new_i,
  input  logic [DW-1:0]     left_i,
  input  logic [DW-1:0]     right_i,
  output logic [DW-1:0]     val_o,
  output logic [DW-1:0]     tap_o
);

  localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(IDX);

  logic [DW-1:0] val_r;
  logic [DW-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (op_i)
      ial_pkg::CELL_OPEN: begin
        if (MY_IDX == at_i) begin
          val_nxt = new_i;
        end else if (MY_IDX > at_i && MY_IDX <= hi_i) begin
          val_nxt = left_i;
        end
      end
      ial_pkg::CELL_CLOSE: begin
        if (MY_IDX >= at_i && MY_IDX < hi_i) begin
          val_nxt = right_i;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;
  assign tap_o = (op_i == ial_pkg::CELL_CLOSE && MY_IDX == at_i) ? val_r : '0;

endmodule

[src/ial_gather.sv]
// registered or-tree that collects the word tapped out of the chain
`timescale 1ns / 1ps
module ial_gather #(
  parameter int DW    = ial_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = ial_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic [DW-1:0] taps_i [DEPTH],
  output logic [DW-1:0] word_o
);

  localparam int NGRP = (DEPTH + ial_pkg::GROUP - 1) / ial_pkg::GROUP;

  logic [DW-1:0] grp_r   [NGRP];
  logic [DW-1:0] grp_nxt [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < ial_pkg::GROUP; j++) begin
        if (g * ial_pkg::GROUP + j < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | taps_i[g * ial_pkg::GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_r[g] <= grp_nxt[g];
    end
  end

  always_comb begin
    word_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      word_o = word_o | grp_r[g];
    end
  end

endmodule

[src/indexed_array_list_engine_core.sv]
// top level: packed list of DEPTH entries in a chain of shifting cells
// result path: the tapped word is registered in the gather groups, then in the output registers with the strobe
// busy is high in the gather state, so a new command is not accepted until the previous one has left it
// all cells that must move shift together in the accept cycle, so inserts and removes at any index cost the same
// reset: synchronous active-low rst_n clears the count, state, status and strobe; entries keep contents
`timescale 1ns / 1ps
module indexed_array_list_engine_core #(
  parameter int DEPTH      = ial_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ial_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [ial_pkg::CMD_W-1:0]           in_cmd,
  input  logic [ial_pkg::POS_W-1:0]           in_position,
  input  logic signed [ial_pkg::VAL_W-1:0]    in_value_in,
  output logic                                out_strobe,
  output logic signed [ial_pkg::VAL_W-1:0]    out_value_out,
  output logic [ial_pkg::CNT_OUT_W-1:0]       out_count,
  output logic [ial_pkg::STAT_W-1:0]          out_status
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > ial_pkg::POS_W) ? CNT_W : ial_pkg::POS_W;

  ial_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  ial_pkg::status_t stat_r, stat_nxt;

  logic                           out_strobe_r, out_strobe_nxt;
  logic [ial_pkg::VAL_W-1:0]      out_value_r;
  logic [ial_pkg::CNT_OUT_W-1:0]  out_count_r;
  logic [ial_pkg::STAT_W-1:0]     out_status_r;

  logic              accept;
  logic              busy_int;
  ial_pkg::cell_op_t cell_op;
  logic [CMP_W-1:0]  at_idx;
  logic [CMP_W-1:0]  hi_idx;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              full;
  logic              empty;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] gathered;

  logic [DATA_WIDTH-1:0] vals [DEPTH];
  logic [DATA_WIDTH-1:0] taps [DEPTH];

  assign accept   = start && !busy_int;
  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign new_word = DATA_WIDTH'(in_value_in);

  // command decode
  always_comb begin
    cell_op   = ial_pkg::CELL_HOLD;
    at_idx    = '0;
    hi_idx    = cnt_ext;
    stat_nxt  = ial_pkg::STAT_DONE;
    count_nxt = count_r;
    if (accept) begin
      case (in_cmd)
        ial_pkg::CMD_APPEND, ial_pkg::CMD_PREPEND, ial_pkg::CMD_INSERT: begin
          if (full) begin
            stat_nxt = ial_pkg::STAT_FULL;
          end else if (in_cmd == ial_pkg::CMD_INSERT && pos_ext > cnt_ext) begin
            stat_nxt = ial_pkg::STAT_RANGE;
          end else begin
            cell_op   = ial_pkg::CELL_OPEN;
            hi_idx    = cnt_ext;
            count_nxt = count_r + 1'b1;
            if (in_cmd == ial_pkg::CMD_APPEND) begin
              at_idx = cnt_ext;
            end else if (in_cmd == ial_pkg::CMD_INSERT) begin
              at_idx = pos_ext;
            end
          end
        end
        ial_pkg::CMD_REMOVE_END, ial_pkg::CMD_REMOVE_START, ial_pkg::CMD_REMOVE_AT: begin
          if (empty) begin
            stat_nxt = ial_pkg::STAT_EMPTY;
          end else if (in_cmd == ial_pkg::CMD_REMOVE_AT && pos_ext >= cnt_ext) begin
            stat_nxt = ial_pkg::STAT_RANGE;
          end else begin
            cell_op   = ial_pkg::CELL_CLOSE;
            hi_idx    = cnt_ext - 1'b1;
            count_nxt = count_r - 1'b1;
            if (in_cmd == ial_pkg::CMD_REMOVE_END) begin
              at_idx = cnt_ext - 1'b1;
            end else if (in_cmd == ial_pkg::CMD_REMOVE_AT) begin
              at_idx = pos_ext;
            end
          end
        end
        default: stat_nxt = ial_pkg::STAT_DONE;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ial_pkg::S_IDLE:   if (accept) state_nxt = ial_pkg::S_GATHER;
      ial_pkg::S_GATHER: state_nxt = ial_pkg::S_IDLE;
      default:           state_nxt = ial_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy_int       = 1'b0;
    out_strobe_nxt = 1'b0;
    case (state_r)
      ial_pkg::S_IDLE: begin
        busy_int       = 1'b0;
        out_strobe_nxt = 1'b0;
      end
      ial_pkg::S_GATHER: begin
        busy_int       = 1'b1;
        out_strobe_nxt = 1'b1;
      end
      default: begin
        busy_int       = 1'b0;
        out_strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ial_pkg::S_IDLE;
      count_r      <= '0;
      stat_r       <= ial_pkg::STAT_DONE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (accept) begin
        stat_r <= stat_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ial_pkg::S_GATHER) begin
      out_value_r  <= ial_pkg::VAL_W'(gathered);
      out_count_r  <= ial_pkg::CNT_OUT_W'(count_r);
      out_status_r <= stat_r;
    end
  end

  // cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w;
    logic [DATA_WIDTH-1:0] right_w;
    if (k == 0) begin : g_first
      assign left_w = new_word;
    end else begin : g_mid_l
      assign left_w = vals[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = vals[k];
    end else begin : g_mid_r
      assign right_w = vals[k+1];
    end
    ial_cell #(
      .DW    (DATA_WIDTH),
      .CMP_W (CMP_W),
      .IDX   (k)
    ) u_cell (
      .clk     (clk),
      .op_i    (cell_op),
      .at_i    (at_idx),
      .hi_i    (hi_idx),
      .new_i   (new_word),
      .left_i  (left_w),
      .right_i (right_w),
      .val_o   (vals[k]),
      .tap_o   (taps[k])
    );
  end

  ial_gather #(
    .DW    (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_gather (
    .clk    (clk),
    .taps_i (taps),
    .word_o (gathered)
  );

  assign busy          = busy_int;
  assign out_strobe    = out_strobe_r;
  assign out_value_out = out_value_r;
  assign out_count     = out_count_r;
  assign out_status    = out_status_r;

endmodule

[src/ial_checker.sv]
// port-level checks for the indexed array list engine
`timescale 1ns / 1ps
`include "indexed_array_list_engine_core_macros.svh"
module ial_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_strobe,
  input logic signed [ial_pkg::VAL_W-1:0]   out_value_out,
  input logic [ial_pkg::CNT_OUT_W-1:0]      out_count,
  input logic [ial_pkg::STAT_W-1:0]         out_status
);

  `IAL_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `IAL_ASSERT(a_accept_reply, (start && !busy) |-> ##2 out_strobe, "no result two cycles after accept")
  `IAL_ASSERT(a_strobe_after_busy, out_strobe |-> $past(busy), "result without a command in flight")
  `IAL_ASSERT(a_reject_zero, (out_strobe && out_status != ial_pkg::STAT_DONE) |-> (out_value_out == '0), "rejected command returned a value")
  `IAL_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_strobe, "result strobe right after reset")

endmodule

bind indexed_array_list_engine_core ial_checker u_ial_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_value_out (out_value_out),
  .out_count     (out_count),
  .out_status    (out_status)
);
